// ===== src/nbtp_pkg.sv =====
package nbtp_pkg;

  localparam int REGION_COUNT_DEF = 64;
  localparam int MAX_NESTING_DEF  = 255;

  localparam int CMD_W   = 2;
  localparam int ID_W    = 8;
  localparam int TS_W    = 48;
  localparam int TOT_W   = 64;
  localparam int DEPTH_W = 8;
  localparam int FRAC_W  = 17;
  localparam int STAT_W  = 2;

  // Q1.16 quotient: one bit per divider step
  localparam int DIV_STEPS = 16;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam logic [FRAC_W-1:0] ONE_Q16 = FRAC_W'(1 << DIV_STEPS);

  localparam logic [CMD_W-1:0] CMD_ENTER = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LEAVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd3;

  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_BAD_ID  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NO_ENTR = 2'd2;
  localparam logic [STAT_W-1:0] STAT_NEST_OV = 2'd3;

  // one table row
  typedef struct packed {
    logic [TOT_W-1:0]   total;
    logic [TS_W-1:0]    entry;
    logic [DEPTH_W-1:0] depth;
  } ent_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_STEPS-1:0] quot;
  } div_rsp_t;

endpackage

// ===== src/nbtp_ram.sv =====
module nbtp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  logic [WIDTH-1:0]      wdata,
  input  logic [AW-1:0]         raddr,
  output logic [WIDTH-1:0]      rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/nbtp_div.sv =====
module nbtp_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                go,
  input  logic [nbtp_pkg::TOT_W-1:0]          num,
  input  logic [nbtp_pkg::TOT_W-1:0]          den,
  output nbtp_pkg::div_rsp_t                  rsp
);
  // restoring division, one quotient bit per cycle; caller ensures num < den
  logic                                 run_r;
  logic                                 done_r;
  logic [nbtp_pkg::DIV_CNT_W-1:0]       cnt_r;
  logic [nbtp_pkg::TOT_W-1:0]           rem_r;
  logic [nbtp_pkg::TOT_W-1:0]           den_r;
  logic [nbtp_pkg::DIV_STEPS-1:0]       q_r;

  logic [nbtp_pkg::TOT_W:0]             sh;
  logic [nbtp_pkg::TOT_W:0]             diff;
  logic                                 ge;
  logic [nbtp_pkg::TOT_W-1:0]           rem_nxt;
  logic [nbtp_pkg::DIV_STEPS-1:0]       q_nxt;

  always_comb begin
    sh      = {rem_r, 1'b0};
    diff    = sh - {1'b0, den_r};
    ge      = (sh >= {1'b0, den_r});
    rem_nxt = ge ? diff[nbtp_pkg::TOT_W-1:0] : sh[nbtp_pkg::TOT_W-1:0];
    q_nxt   = {q_r[nbtp_pkg::DIV_STEPS-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == nbtp_pkg::DIV_CNT_W'(nbtp_pkg::DIV_STEPS - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rem_r <= num;
      den_r <= den;
      q_r   <= '0;
    end else if (run_r) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;

endmodule

// ===== src/nested_block_time_profiler.sv =====
// Clear or a bad region id is answered in the cycle after accept; enter and leave do a
// table read, then write-back; query does two table reads, then the 16-step divider,
// skipping it when region 0's total is zero or the ratio saturates. One command at a
// time: busy covers the cycles between accept and strobe, so clear and a bad id never raise it.
// Reset (synchronous, rst_n low) zeroes all depths and totals via per-row valid
// bits, with no clearing pass. The receiver cannot stall: out_valid lasts one cycle.
module nested_block_time_profiler #(
  parameter int REGION_COUNT = nbtp_pkg::REGION_COUNT_DEF,
  parameter int MAX_NESTING  = nbtp_pkg::MAX_NESTING_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [nbtp_pkg::CMD_W-1:0]    in_command,
  input  logic [nbtp_pkg::ID_W-1:0]     in_block_id,
  input  logic [nbtp_pkg::TS_W-1:0]     in_timestamp,
  output logic                          out_valid,
  output logic [nbtp_pkg::FRAC_W-1:0]   out_fraction,
  output logic [nbtp_pkg::TOT_W-1:0]    out_total_time,
  output logic [nbtp_pkg::STAT_W-1:0]   out_status
);
  localparam int AW    = (REGION_COUNT > 1) ? $clog2(REGION_COUNT) : 1;
  localparam int ENT_W = $bits(nbtp_pkg::ent_t);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_READ  = 4'b0010,
    ST_READ0 = 4'b0100,
    ST_DIV   = 4'b1000
  } state_t;

  state_t                          state_r, state_nxt;
  logic [nbtp_pkg::CMD_W-1:0]      cmd_r;
  logic [AW-1:0]                   id_r;
  logic [nbtp_pkg::TS_W-1:0]       ts_r;
  logic [nbtp_pkg::TOT_W-1:0]      num_r, num_nxt;
  logic [REGION_COUNT-1:0]         dep_vld_r, tot_vld_r;

  logic                            out_valid_r, out_valid_nxt;
  logic [nbtp_pkg::FRAC_W-1:0]     out_fraction_r, out_fraction_nxt;
  logic [nbtp_pkg::TOT_W-1:0]      out_total_time_r, out_total_time_nxt;
  logic [nbtp_pkg::STAT_W-1:0]     out_status_r, out_status_nxt;

  logic                            ram_we;
  logic [AW-1:0]                   ram_raddr;
  nbtp_pkg::ent_t                  ram_wdata, rd_ent;
  logic [ENT_W-1:0]                ram_rdata;

  logic                            accept, id_ok;
  logic                            clr_tot, set_vld;
  logic [nbtp_pkg::DEPTH_W-1:0]    cur_depth, new_depth;
  logic [nbtp_pkg::TOT_W-1:0]      cur_total, den;
  logic [nbtp_pkg::TS_W-1:0]       elapsed;
  logic                            div_go;
  nbtp_pkg::div_rsp_t              div_rsp;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;
  assign id_ok  = ({1'b0, in_block_id} < 9'(REGION_COUNT));

  assign rd_ent    = nbtp_pkg::ent_t'(ram_rdata);
  assign cur_depth = dep_vld_r[id_r] ? rd_ent.depth : '0;
  assign cur_total = tot_vld_r[id_r] ? rd_ent.total : '0;
  assign den       = tot_vld_r[0] ? rd_ent.total : '0;
  assign elapsed   = ts_r - rd_ent.entry;

  always_comb begin
    state_nxt          = state_r;
    num_nxt            = num_r;
    out_valid_nxt      = 1'b0;
    out_fraction_nxt   = '0;
    out_total_time_nxt = '0;
    out_status_nxt     = nbtp_pkg::STAT_OK;
    ram_we             = 1'b0;
    ram_raddr          = in_block_id[AW-1:0];
    ram_wdata          = rd_ent;
    clr_tot            = 1'b0;
    set_vld            = 1'b0;
    div_go             = 1'b0;
    new_depth          = cur_depth;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_command == nbtp_pkg::CMD_CLEAR) begin
            clr_tot       = 1'b1;
            out_valid_nxt = 1'b1;
          end else if (!id_ok) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = nbtp_pkg::STAT_BAD_ID;
          end else begin
            state_nxt = ST_READ;
          end
        end
      end
      ST_READ: begin
        ram_wdata.total    = cur_total;
        ram_wdata.depth    = cur_depth;
        out_total_time_nxt = cur_total;
        case (cmd_r)
          nbtp_pkg::CMD_ENTER: begin
            out_valid_nxt = 1'b1;
            state_nxt     = ST_IDLE;
            if (cur_depth >= nbtp_pkg::DEPTH_W'(MAX_NESTING)) begin
              out_status_nxt = nbtp_pkg::STAT_NEST_OV;
            end else begin
              if (cur_depth == '0) begin
                ram_wdata.entry = ts_r;
              end
              ram_wdata.depth = cur_depth + 1'b1;
              ram_we          = 1'b1;
              set_vld         = 1'b1;
            end
          end
          nbtp_pkg::CMD_LEAVE: begin
            out_valid_nxt = 1'b1;
            state_nxt     = ST_IDLE;
            if (cur_depth == '0) begin
              out_status_nxt = nbtp_pkg::STAT_NO_ENTR;
            end else begin
              new_depth       = cur_depth - 1'b1;
              ram_wdata.depth = new_depth;
              if (new_depth == '0) begin
                ram_wdata.total    = cur_total + {{(nbtp_pkg::TOT_W-nbtp_pkg::TS_W){1'b0}},
                                                  elapsed};
                out_total_time_nxt = ram_wdata.total;
              end
              ram_we  = 1'b1;
              set_vld = 1'b1;
            end
          end
          default: begin
            // query: keep the numerator, fetch region 0
            num_nxt   = cur_total;
            ram_raddr = '0;
            state_nxt = ST_READ0;
          end
        endcase
      end
      ST_READ0: begin
        out_total_time_nxt = num_r;
        if (den == '0) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else if (num_r >= den) begin
          out_valid_nxt    = 1'b1;
          out_fraction_nxt = nbtp_pkg::ONE_Q16;
          state_nxt        = ST_IDLE;
        end else begin
          div_go    = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        out_total_time_nxt = num_r;
        if (div_rsp.done) begin
          out_valid_nxt    = 1'b1;
          out_fraction_nxt = {1'b0, div_rsp.quot};
          state_nxt        = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      dep_vld_r   <= '0;
      tot_vld_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (clr_tot) begin
        tot_vld_r <= '0;
      end else if (set_vld) begin
        tot_vld_r[id_r] <= 1'b1;
      end
      if (set_vld) begin
        dep_vld_r[id_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_command;
      id_r  <= in_block_id[AW-1:0];
      ts_r  <= in_timestamp;
    end
    num_r            <= num_nxt;
    out_fraction_r   <= out_fraction_nxt;
    out_total_time_r <= out_total_time_nxt;
    out_status_r     <= out_status_nxt;
  end

  nbtp_ram #(
    .WIDTH (ENT_W),
    .DEPTH (REGION_COUNT)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (id_r),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  nbtp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (div_go),
    .num   (num_r),
    .den   (den),
    .rsp   (div_rsp)
  );

  assign out_valid      = out_valid_r;
  assign out_fraction   = out_fraction_r;
  assign out_total_time = out_total_time_r;
  assign out_status     = out_status_r;

  // a table access for a valid region must leave idle
  a_busy_after_access: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && id_ok && in_command != nbtp_pkg::CMD_CLEAR) |=> busy)
    else $error("table access did not raise busy");

  // divider finishes only while the query waits for it
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == ST_DIV))
    else $error("divider done outside query");

  a_frac_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_fraction_r <= nbtp_pkg::ONE_Q16))
    else $error("fraction above 1.0");

  // the table is written only while finishing an enter or leave
  a_write_in_read: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_READ && state_nxt == ST_IDLE))
    else $error("table write outside update step");

endmodule

// ===== tb/sv/nested_block_time_profiler_tb.sv =====
`timescale 1ns / 100ps

module nested_block_time_profiler_tb;
  import nbtp_pkg::*;

  localparam int NREG       = REGION_COUNT_DEF;
  localparam int NEST_MAX   = MAX_NESTING_DEF;
  localparam int STALL_LIMIT = 2000;
  localparam logic [TS_W-1:0] TS_MAX = '1;

  typedef struct packed {
    logic [FRAC_W-1:0] fraction;
    logic [TOT_W-1:0]  total;
    logic [STAT_W-1:0] status;
  } answer_t;

  logic                clk;
  logic                rst_n        = 1'b0;
  logic                start        = 1'b0;
  logic [CMD_W-1:0]    in_command   = '0;
  logic [ID_W-1:0]     in_block_id  = '0;
  logic [TS_W-1:0]     in_timestamp = '0;
  logic                busy;
  logic                out_valid;
  logic [FRAC_W-1:0]   out_fraction;
  logic [TOT_W-1:0]    out_total_time;
  logic [STAT_W-1:0]   out_status;

  nested_block_time_profiler uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_command     (in_command),
    .in_block_id    (in_block_id),
    .in_timestamp   (in_timestamp),
    .out_valid      (out_valid),
    .out_fraction   (out_fraction),
    .out_total_time (out_total_time),
    .out_status     (out_status)
  );

  // predictor copy of the region table
  logic [DEPTH_W-1:0] region_depth [NREG];
  logic [TS_W-1:0]    region_entry [NREG];
  logic [TOT_W-1:0]   region_sum   [NREG];

  answer_t pending_answers[$];
  int      fail_count = 0;
  bit      gaps_on    = 1'b1;
  logic [TS_W-1:0] clock_now = '0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // floor(num * 2^16 / den) for num < den
  function automatic logic [FRAC_W-1:0] share_q16(logic [TOT_W-1:0] num,
                                                  logic [TOT_W-1:0] den);
    logic [TOT_W+15:0] scaled;
    logic [TOT_W+15:0] quo;
    if (num >= den) return ONE_Q16;
    scaled = {num, 16'd0};
    quo    = scaled / {16'd0, den};
    return quo[FRAC_W-1:0];
  endfunction

  function automatic answer_t profile_event(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id,
                                            logic [TS_W-1:0] ts);
    answer_t a;
    logic [TS_W-1:0] span;
    a = '0;
    if (cmd == CMD_CLEAR) begin
      for (int r = 0; r < NREG; r++) region_sum[r] = '0;
    end else if (int'(id) >= NREG) begin
      a.status = STAT_BAD_ID;
    end else if (cmd == CMD_ENTER) begin
      if (int'(region_depth[id]) >= NEST_MAX) begin
        a.status = STAT_NEST_OV;
      end else begin
        if (region_depth[id] == '0) region_entry[id] = ts;
        region_depth[id] = region_depth[id] + 1'b1;
      end
      a.total = region_sum[id];
    end else if (cmd == CMD_LEAVE) begin
      if (region_depth[id] == '0) begin
        a.status = STAT_NO_ENTR;
      end else begin
        region_depth[id] = region_depth[id] - 1'b1;
        if (region_depth[id] == '0) begin
          span = ts - region_entry[id];
          region_sum[id] = region_sum[id] + {{(TOT_W-TS_W){1'b0}}, span};
        end
      end
      a.total = region_sum[id];
    end else begin
      a.total = region_sum[id];
      if (region_sum[0] != '0) a.fraction = share_q16(region_sum[id], region_sum[0]);
    end
    return a;
  endfunction

  // one beat on the command port; called just after a rising edge
  task automatic issue_event(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id,
                             logic [TS_W-1:0] ts);
    if (gaps_on) begin
      while ($urandom_range(99) < 23) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start        <= 1'b1;
    in_command   <= cmd;
    in_block_id  <= id;
    in_timestamp <= ts;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_answers.push_back(profile_event(cmd, id, ts));
  endtask

  always @(posedge clk) begin
    answer_t want;
    if (rst_n && out_valid) begin
      if (pending_answers.size() == 0) begin
        $display("%0t: result with nothing pending: fraction %0d total %0d status %0d",
                 $time, out_fraction, out_total_time, out_status);
        fail_count++;
      end else begin
        want = pending_answers.pop_front();
        if (out_fraction !== want.fraction) begin
          $display("%0t: fraction expected %0d actual %0d", $time, want.fraction,
                   out_fraction);
          fail_count++;
        end
        if (out_total_time !== want.total) begin
          $display("%0t: total_time expected %0d actual %0d", $time, want.total,
                   out_total_time);
          fail_count++;
        end
        if (out_status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status,
                   out_status);
          fail_count++;
        end
      end
    end
  end

  // ends the run when neither a command nor a result moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || out_valid) quiet = 0;
      else quiet++;
    end
    $display("simulation failed");
    $finish;
  end

  task automatic test_reset_state();
    issue_event(CMD_QUERY, 8'd0, '0);    // zero denominator
    issue_event(CMD_LEAVE, 8'd3, '0);    // leave without enter
    issue_event(CMD_QUERY, 8'd63, TS_MAX);
  endtask

  task automatic test_directed();
    issue_event(CMD_ENTER, 8'd0, '0);
    issue_event(CMD_LEAVE, 8'd0, TS_MAX);   // longest span
    issue_event(CMD_QUERY, 8'd0, '0);       // region 0 over itself
    issue_event(CMD_ENTER, 8'd63, TS_MAX);
    issue_event(CMD_LEAVE, 8'd63, '0);      // counter wrapped
    issue_event(CMD_QUERY, 8'd63, '0);
    issue_event(CMD_ENTER, 8'd1, 48'd100);
    issue_event(CMD_ENTER, 8'd1, 48'd200);  // nested, entry kept
    issue_event(CMD_LEAVE, 8'd1, 48'd300);
    issue_event(CMD_LEAVE, 8'd1, 48'd1000);
    issue_event(CMD_QUERY, 8'd1, '0);
    issue_event(CMD_ENTER, 8'd64, 48'd5);
    issue_event(CMD_LEAVE, 8'd255, 48'd5);
    issue_event(CMD_QUERY, 8'd128, 48'd5);
    issue_event(CMD_ENTER, 8'd5, 48'd1);
    issue_event(CMD_LEAVE, 8'd5, '0);       // equals region 0
    issue_event(CMD_ENTER, 8'd5, '0);
    issue_event(CMD_LEAVE, 8'd5, 48'd5);    // now above region 0
    issue_event(CMD_QUERY, 8'd5, '0);       // saturates
    issue_event(CMD_ENTER, 8'd2, 48'd50);
    issue_event(CMD_CLEAR, 8'd255, TS_MAX);
    issue_event(CMD_QUERY, 8'd0, '0);
    issue_event(CMD_LEAVE, 8'd2, 48'd80);   // depth survived the clear
    issue_event(CMD_QUERY, 8'd2, '0);
    issue_event(CMD_CLEAR, 8'd0, '0);
  endtask

  task automatic test_nesting_limit();
    for (int k = 0; k < NEST_MAX; k++) issue_event(CMD_ENTER, 8'd2, 48'(k));
    issue_event(CMD_ENTER, 8'd2, 48'd999);     // overflow
    for (int k = 0; k < NEST_MAX; k++) issue_event(CMD_LEAVE, 8'd2, 48'(1000 + k));
    issue_event(CMD_LEAVE, 8'd2, 48'd5000);    // one too many
    issue_event(CMD_QUERY, 8'd2, '0);
  endtask

  function automatic logic [ID_W-1:0] pick_region();
    int r;
    r = $urandom_range(99);
    if (r < 25) return 8'd0;
    if (r < 75) return ID_W'($urandom_range(1, 7));
    return ID_W'($urandom_range(0, NREG - 1));
  endfunction

  task automatic test_random_traffic(int n_items);
    logic [CMD_W-1:0] cmd;
    logic [ID_W-1:0]  id;
    int pick, off;
    for (int i = 0; i < n_items; i++) begin
      gaps_on = !(i >= 300 && i < 560);
      pick = $urandom_range(99);
      pick = $urandom_range(99);
      if ($urandom_range(99) < 80) clock_now = clock_now + TS_W'($urandom_range(1, 4000));
      else if ($urandom_range(99) < 75) clock_now = clock_now + TS_W'($urandom);
      else clock_now = TS_W'({$urandom, $urandom});  // jump anywhere, may wrap
      id = pick_region();
      if (pick < 40) begin
        cmd = CMD_ENTER;
      end else if (pick < 78) begin
        cmd = CMD_LEAVE;
        // mostly close a region that is open
        if (region_depth[id] == '0 && $urandom_range(4) != 0) begin
          off = $urandom_range(7);
          for (int j = 0; j < 8; j++)
            if (region_depth[(off + j) % 8] != '0) id = ID_W'((off + j) % 8);
        end
      end else if (pick < 81) begin
        cmd = CMD_CLEAR;
        id  = ID_W'($urandom_range(0, 255));
      end else if (pick < 95) begin
        cmd = CMD_QUERY;
      end else begin
        cmd = CMD_W'($urandom_range(0, 3));
        id  = ID_W'($urandom_range(NREG, 255));
      end
      issue_event(cmd, id, clock_now);
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    for (int r = 0; r < NREG; r++) begin
      region_depth[r] = '0;
      region_entry[r] = '0;
      region_sum[r]   = '0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_directed();
    test_nesting_limit();
    test_random_traffic(609);
    start <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (25) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
